### design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial division prime tester: the status bundle that
// the bit-serial remainder unit returns to the sequencer.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Status of the remainder unit towards the sequencer
    typedef struct packed {
        logic done;     // one-cycle pulse: remainder is ready
        logic is_zero;  // remainder is zero (valid with done)
    } t_rem_status;

    // Width in bits of the result stream data
    localparam int unsigned RESULT_TDATA_W = 8;

endpackage

### design/tdpt_rem.sv
// ----------------------------------------------------------------------------
// tdpt_rem
// Bit-serial restoring remainder: the dividend shifts in one bit per cycle,
// MSB first, and the divisor is subtracted from the partial remainder whenever it fits.
// ----------------------------------------------------------------------------
module tdpt_rem #(
    parameter int VALUE_WIDTH = 27
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [VALUE_WIDTH-1:0]    i_dividend,
    input  logic [VALUE_WIDTH-1:0]    i_divisor,   // held stable while busy
    output tdpt_pkg::t_rem_status     o_status
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_shift, n_shift;
    logic [VALUE_WIDTH-1:0] r_rem,   n_rem;
    logic [CNT_W-1:0]       r_cnt,   n_cnt;
    logic                   r_busy,  n_busy;
    logic                   r_done,  n_done;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;

    // One restoring step
    assign trial = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = (trial >= {1'b0, i_divisor});

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_dividend;
            n_rem   = '0;
            n_cnt   = CNT_W'(VALUE_WIDTH);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
            n_rem   = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            n_cnt   = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_status.done    = r_done;
    assign o_status.is_zero = (r_rem == '0);

endmodule

### design/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by odd trial division, one bit-serial remainder per divisor.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Signals                         | Payload
//  ---------+-----+---------------------------------+-------------------------
//  s (in)   | in  | i_s_tvalid/o_s_tready/i_s_tdata | candidate
//  m (out)  | out | o_m_tvalid/i_m_tready/o_m_tdata | is_prime
//
//  Zero, one, two and even numbers go straight to the result; otherwise
//  the test runs one remainder for each of k odd divisors tried (k up to
//  sqrt(n)/2), the remainder unit taking one dividend bit per cycle.
//  One request is worked on at a time; o_s_tready is high only when idle.
//  A finished result waits in the output register while a new request is
//  taken; a stalled output holds the sequencer at its final step.
//  Reset is synchronous, active low, and clears all control state.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 27
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    i_s_tdata,  // [VALUE_WIDTH-1:0] candidate
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [tdpt_pkg::RESULT_TDATA_W-1:0] o_m_tdata   // [0] is_prime
);

    localparam int SQ_W = VALUE_WIDTH + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_cand,  n_cand;
    logic [VALUE_WIDTH-1:0] r_div,   n_div;
    logic [SQ_W-1:0]        r_sq,    n_sq;
    logic                   r_res,   n_res;
    logic                   r_ovld,  n_ovld;
    logic                   r_out,   n_out;
    logic                   rem_start;
    tdpt_pkg::t_rem_status  rem_status;

    logic                   in_req;
    logic [VALUE_WIDTH-1:0] in_cand;

    assign in_req  = i_s_tvalid && o_s_tready;
    assign in_cand = i_s_tdata[VALUE_WIDTH-1:0];

    // Remainder unit
    tdpt_rem #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_status   (rem_status)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cand    = r_cand;
        n_div     = r_div;
        n_sq      = r_sq;
        n_res     = r_res;
        n_ovld    = r_ovld;
        n_out     = r_out;
        rem_start = 1'b0;

        // output register drains independently
        if (r_ovld && i_m_tready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_req) begin
                    n_cand = in_cand;
                    n_div  = VALUE_WIDTH'(3);
                    n_sq   = SQ_W'(9);
                    priority if (in_cand <= VALUE_WIDTH'(1)) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else if (in_cand == VALUE_WIDTH'(2)) begin
                        n_res   = 1'b1;
                        n_state = S_DONE;
                    end else if (!in_cand[0]) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                // divisor squared beyond the candidate: no factor left
                if (r_sq > {2'b00, r_cand}) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rem_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_status.done) begin
                    if (rem_status.is_zero) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        // (d+2)^2 = d^2 + 4d + 4
                        n_div   = r_div + VALUE_WIDTH'(2);
                        n_sq    = r_sq + {r_div, 2'b00} + SQ_W'(4);
                        n_state = S_LOOP;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovld || i_m_tready) begin
                    n_ovld  = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_div  <= n_div;
        r_sq   <= n_sq;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {{(tdpt_pkg::RESULT_TDATA_W-1){1'b0}}, r_out};

endmodule

### design/tdpt_check.sv
// ----------------------------------------------------------------------------
// tdpt_check
// Port-level checks for the trial division prime tester, bound to the top.
// ----------------------------------------------------------------------------
module tdpt_check #(
    parameter int VALUE_WIDTH = 27
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [((VALUE_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [tdpt_pkg::RESULT_TDATA_W-1:0] o_m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Once a request is taken the input is no longer ready
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while a test is in progress");

    // Result padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[tdpt_pkg::RESULT_TDATA_W-1:1] == '0))
        else $error("result padding not zero");

    // Reset empties the output and readies the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not clear the block");

    // A new result never appears while the previous one is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready && o_s_tready |=> o_m_tvalid)
        else $error("stalled result dropped");

endmodule

bind trial_division_prime_test tdpt_check #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tdpt_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
